>>> rtl/rwdf_pkg.sv
package rwdf_pkg;

  localparam int unsigned AddrW = 7;
  localparam int unsigned ValueW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned DgramLen = 8;
  localparam int unsigned IdxW = 3;

  localparam logic [IdxW-1:0] IdxSync = 3'd0;
  localparam logic [IdxW-1:0] IdxNode = 3'd1;
  localparam logic [IdxW-1:0] IdxAddr = 3'd2;
  localparam logic [IdxW-1:0] IdxVal3 = 3'd3;
  localparam logic [IdxW-1:0] IdxVal2 = 3'd4;
  localparam logic [IdxW-1:0] IdxVal1 = 3'd5;
  localparam logic [IdxW-1:0] IdxVal0 = 3'd6;
  localparam logic [IdxW-1:0] IdxCrc = 3'd7;

  localparam logic [ByteW-1:0] SyncByte = 8'h05;
  localparam logic [ByteW-1:0] NodeAddr = 8'h00;
  localparam logic WriteBit = 1'b1;
  localparam logic [ByteW-1:0] CrcPoly = 8'h07;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ValueW-1:0] value;
  } req_t;

  // Shift-left CRC-8, data bits fed LSB first.
  function automatic logic [ByteW-1:0] crc8_update(logic [ByteW-1:0] crc_in,
                                                   logic [ByteW-1:0] data);
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] d;
    crc = crc_in;
    d = data;
    for (int b = 0; b < ByteW; b++) begin
      if (crc[ByteW-1] ^ d[0]) begin
        crc = {crc[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[ByteW-2:0], 1'b0};
      end
      d = {1'b0, d[ByteW-1:1]};
    end
    return crc;
  endfunction

endpackage

>>> rtl/rwdf_req_reg.sv
module rwdf_req_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  rwdf_pkg::req_t req_i,
  output logic          held_valid_o,
  output rwdf_pkg::req_t held_o,
  input  logic          pop_i
);

  logic           valid_q, valid_d;
  rwdf_pkg::req_t req_q;
  logic           accept;

  assign req_stall_o = valid_q && !pop_i;
  assign accept = req_valid_i && !req_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_o = req_q;

endmodule

>>> rtl/rwdf_byte_out.sv
module rwdf_byte_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           held_valid_i,
  input  rwdf_pkg::req_t                 held_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rwdf_pkg::ByteW-1:0]     tx_byte_o,
  output logic                           last_byte_o
);

  logic                          out_valid_q, out_valid_d;
  logic [rwdf_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [rwdf_pkg::ByteW-1:0]    crc_q, crc_d;
  logic [rwdf_pkg::ByteW-1:0]    tx_byte_q;
  logic                          last_q;
  logic [rwdf_pkg::ByteW-1:0]    cur_byte;
  logic                          load;
  logic                          is_last;

  assign load = held_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == rwdf_pkg::IdxCrc);
  assign pop_o = load && is_last;

  always_comb begin
    case (idx_q)
      rwdf_pkg::IdxSync: cur_byte = rwdf_pkg::SyncByte;
      rwdf_pkg::IdxNode: cur_byte = rwdf_pkg::NodeAddr;
      rwdf_pkg::IdxAddr: cur_byte = {rwdf_pkg::WriteBit, held_i.addr};
      rwdf_pkg::IdxVal3: cur_byte = held_i.value[31:24];
      rwdf_pkg::IdxVal2: cur_byte = held_i.value[23:16];
      rwdf_pkg::IdxVal1: cur_byte = held_i.value[15:8];
      rwdf_pkg::IdxVal0: cur_byte = held_i.value[7:0];
      default:           cur_byte = crc_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d = idx_q;
    crc_d = crc_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d = idx_q + 1'b1;
      // restart the checksum after the CRC byte goes out
      crc_d = is_last ? rwdf_pkg::CrcInit : rwdf_pkg::crc8_update(crc_q, cur_byte);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q <= rwdf_pkg::IdxSync;
      crc_q <= rwdf_pkg::CrcInit;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_byte_q <= cur_byte;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o = tx_byte_q;
  assign last_byte_o = last_q;

endmodule

>>> rtl/register_write_datagram_framer.sv
// Register write datagram framer: one request in, eight datagram bytes out.
// The request is held in a register, then each byte is registered at the output.
// Throughput: one byte per cycle while out_stall_i is low, set by the
// single byte-wide output register; the next request is taken as the CRC byte loads.
// Reset (rst_ni, async, active low) empties both registers and restarts the CRC.
module register_write_datagram_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rwdf_pkg::AddrW-1:0]  reg_address_i,
  input  logic [rwdf_pkg::ValueW-1:0] reg_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rwdf_pkg::ByteW-1:0]  tx_byte_o,
  output logic                        last_byte_o
);

  rwdf_pkg::req_t req_in;
  rwdf_pkg::req_t held;
  logic           held_valid;
  logic           pop;

  assign req_in.addr = reg_address_i;
  assign req_in.value = reg_value_i;

  rwdf_req_reg u_req_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (req_in),
    .held_valid_o(held_valid),
    .held_o      (held),
    .pop_i       (pop)
  );

  rwdf_byte_out u_byte_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .held_valid_i(held_valid),
    .held_i      (held),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule
